>>> design/pbsa_pkg.sv
// pbsa_pkg: shared types and constants for the paged bitmap slot allocator
// used by the controller, datapath, top level and checker
`default_nettype none
package pbsa_pkg;
   localparam int NUM_PAGES      = 16;
   localparam int SLOTS_PER_PAGE = 32;
   localparam int PAGE_W  = 4;
   localparam int SLOT_W  = 5;
   localparam int LINK_W  = PAGE_W + 1;
   localparam int COUNT_W = 10;
   localparam logic [LINK_W-1:0] NULL_PAGE = LINK_W'(NUM_PAGES);
   localparam logic [SLOTS_PER_PAGE-1:0] FULL_MASK = '1;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_PROVIDE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;
   localparam logic [1:0] ST_PRESENT = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [PAGE_W-1:0] page_id;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PAGE_W-1:0]  alloc_page;
      logic [SLOT_W-1:0]  alloc_slot;
      logic               need_refill;
      logic               page_released;
      logic [COUNT_W-1:0] free_total;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_WALK, S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request
      logic exec;    // decide and apply the request
      logic walk;    // one step of the list walk for unlink
      logic finish;  // publish result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_walk;
      logic walk_done;
   } sts_type;
endpackage
`default_nettype wire

>>> design/paged_bitmap_slot_allocator_core.sv
// paged_bitmap_slot_allocator_core: top level, controller plus datapath
// depends on pbsa_pkg, pbsa_ctrl, pbsa_dp
//
// One request is handled at a time. Allocate, provide and most frees pass
// through the execute and done states, then load the result register. A free
// that releases a page not at the list head walks the free list one link per
// cycle in the walk state. The result sits in an output register, so the next
// request is taken while it waits, and a new result is loaded once it has
// been taken.
`default_nettype none
module paged_bitmap_slot_allocator_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pbsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pbsa_pkg::rsp_type      rsp_data
);
   import pbsa_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic    out_busy;

   pbsa_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .out_busy, .sts, .cmd);
   pbsa_dp u_dp (.clock, .reset, .req_data, .cmd, .sts, .rsp_stall, .rsp_valid,
                 .rsp_data, .out_busy);
endmodule
`default_nettype wire

>>> design/pbsa_ctrl.sv
// pbsa_ctrl: sequencer for the slot allocator
// depends on pbsa_pkg
`default_nettype none
module pbsa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             out_busy,
   input  wire pbsa_pkg::sts_type sts,
   output pbsa_pkg::cmd_type     cmd
);
   import pbsa_pkg::*;
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = sts.need_walk ? S_WALK : S_DONE;
         S_WALK: if (sts.walk_done) state_in = S_DONE;
         S_DONE: if (!out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_EXEC: cmd.exec = 1'b1;
         S_WALK: cmd.walk = 1'b1;
         S_DONE: cmd.finish = !out_busy;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> design/pbsa_dp.sv
// pbsa_dp: allocator state, bitmaps, free list and result register
// depends on pbsa_pkg
`default_nettype none
module pbsa_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pbsa_pkg::req_type req_data,
   input  wire pbsa_pkg::cmd_type cmd,
   output pbsa_pkg::sts_type      sts,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output pbsa_pkg::rsp_type      rsp_data,
   output logic                   out_busy
);
   import pbsa_pkg::*;

   logic [SLOTS_PER_PAGE-1:0] used_ff [NUM_PAGES];
   logic [NUM_PAGES-1:0]      present_ff;
   logic [LINK_W-1:0]         next_ff [NUM_PAGES];
   logic [LINK_W-1:0]         head_ff;
   logic [COUNT_W-1:0]        count_ff;
   req_type                   req_ff;
   rsp_type                   res_ff;
   logic [LINK_W-1:0]         cur_ff;
   logic [PAGE_W:0]           guard_ff;
   logic                      rvalid_ff;
   rsp_type                   rdata_ff;

   // decode of the captured request
   logic [PAGE_W-1:0]         hp;
   logic [SLOTS_PER_PAGE-1:0] hbits, pbits, hnew, pnew;
   logic [SLOT_W-1:0]         low_slot;
   logic                      head_ok, free_ok, was_full, do_rel;
   logic [COUNT_W-1:0]        cnt_inc, cnt_dec;
   logic [PAGE_W-1:0]         cp;

   assign hp      = head_ff[PAGE_W-1:0];
   assign hbits   = used_ff[hp];
   assign pbits   = used_ff[req_ff.page_id];
   assign head_ok = (head_ff < NULL_PAGE) && (hbits != FULL_MASK);
   assign cp      = cur_ff[PAGE_W-1:0];

   // lowest free slot
   always_comb begin
      low_slot = '0;
      for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--)
         if (!hbits[i]) low_slot = SLOT_W'(i);
   end

   assign hnew     = hbits | (SLOTS_PER_PAGE'(1) << low_slot);
   assign pnew     = pbits & ~(SLOTS_PER_PAGE'(1) << req_ff.slot_index);
   assign free_ok  = present_ff[req_ff.page_id] && pbits[req_ff.slot_index];
   assign was_full = (pbits == FULL_MASK);
   assign cnt_inc  = count_ff + COUNT_W'(1);
   assign cnt_dec  = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
   assign do_rel   = !was_full && (cnt_inc > COUNT_W'(SLOTS_PER_PAGE + 2))
                     && (req_ff.page_id != '0) && (pnew == '0);

   assign sts.need_walk = cmd.exec && req_ff.action == ACT_FREE && free_ok && do_rel
                          && head_ff != {1'b0, req_ff.page_id};
   assign sts.walk_done = (guard_ff == (PAGE_W+1)'(NUM_PAGES)) || (cur_ff >= NULL_PAGE)
                          || (next_ff[cp] == {1'b0, req_ff.page_id});

   // main state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            used_ff[i] <= '0;
            next_ff[i] <= NULL_PAGE;
         end
         present_ff <= NUM_PAGES'(1);
         head_ff    <= '0;
         count_ff   <= COUNT_W'(SLOTS_PER_PAGE);
      end else begin
         if (cmd.load) req_ff <= req_data;
         if (cmd.exec) begin
            res_ff <= '0;
            cur_ff <= head_ff;
            guard_ff <= '0;
            unique case (req_ff.action)
               ACT_ALLOC: begin
                  if (!head_ok) begin
                     res_ff.status <= ST_NO_FREE;
                     res_ff.need_refill <= count_ff < COUNT_W'(2);
                  end else begin
                     used_ff[hp] <= hnew;
                     count_ff <= cnt_dec;
                     res_ff.alloc_page <= hp;
                     res_ff.alloc_slot <= low_slot;
                     res_ff.need_refill <= cnt_dec < COUNT_W'(2);
                     if (hnew == FULL_MASK) begin
                        head_ff <= next_ff[hp];
                        next_ff[hp] <= NULL_PAGE;
                     end
                  end
               end
               ACT_FREE: begin
                  if (!free_ok) res_ff.status <= ST_BAD;
                  else begin
                     used_ff[req_ff.page_id] <= pnew;
                     if (was_full) begin
                        count_ff <= cnt_inc;
                        next_ff[req_ff.page_id] <= head_ff;
                        head_ff <= {1'b0, req_ff.page_id};
                     end else if (do_rel) begin
                        count_ff <= cnt_inc - COUNT_W'(SLOTS_PER_PAGE);
                        present_ff[req_ff.page_id] <= 1'b0;
                        res_ff.page_released <= 1'b1;
                        if (head_ff == {1'b0, req_ff.page_id}) begin
                           head_ff <= next_ff[req_ff.page_id];
                           next_ff[req_ff.page_id] <= NULL_PAGE;
                        end
                     end else count_ff <= cnt_inc;
                  end
               end
               ACT_PROVIDE: begin
                  if (present_ff[req_ff.page_id]) res_ff.status <= ST_PRESENT;
                  else begin
                     used_ff[req_ff.page_id] <= '0;
                     present_ff[req_ff.page_id] <= 1'b1;
                     next_ff[req_ff.page_id] <= head_ff;
                     head_ff <= {1'b0, req_ff.page_id};
                     count_ff <= count_ff + COUNT_W'(SLOTS_PER_PAGE);
                  end
               end
               default: res_ff.status <= ST_BAD;
            endcase
         end
         // unlink walk, one link per cycle
         if (cmd.walk) begin
            if (sts.walk_done) begin
               if (guard_ff != (PAGE_W+1)'(NUM_PAGES) && cur_ff < NULL_PAGE
                   && next_ff[cp] == {1'b0, req_ff.page_id})
                  next_ff[cp] <= next_ff[req_ff.page_id];
               next_ff[req_ff.page_id] <= NULL_PAGE;
            end else begin
               cur_ff   <= next_ff[cp];
               guard_ff <= guard_ff + 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else if (cmd.finish) rvalid_ff <= 1'b1;
      else if (!rsp_stall) rvalid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.finish) rdata_ff <= '{status: res_ff.status, alloc_page: res_ff.alloc_page,
         alloc_slot: res_ff.alloc_slot, need_refill: res_ff.need_refill,
         page_released: res_ff.page_released, free_total: count_ff};
   end

   assign out_busy  = rvalid_ff && rsp_stall;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rdata_ff;
endmodule
`default_nettype wire

>>> design/pbsa_checker.sv
// pbsa_checker: port-level assertions for the slot allocator
// depends on pbsa_pkg; bound to paged_bitmap_slot_allocator_core
`default_nettype none
module pbsa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire pbsa_pkg::rsp_type rsp_data
);
   import pbsa_pkg::*;
   // held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   // free total never exceeds the pool
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_total <= COUNT_W'(NUM_PAGES * SLOTS_PER_PAGE))
      else $error("free total out of range");
   // an accepted transaction is never followed by acceptance next cycle
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back to back acceptance");
   // a failed transaction reports no slot and no page release
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.alloc_page == '0 && rsp_data.alloc_slot == '0 && !rsp_data.page_released)
      else $error("failed transaction carries data");
endmodule
bind paged_bitmap_slot_allocator_core pbsa_checker u_chk (.clock, .reset, .req_valid,
   .req_stall, .rsp_valid, .rsp_stall, .rsp_data);
`default_nettype wire
